@@ hw/rtl/uartle_pkg.sv @@
// shared types and constants for the uart line echo unit
// no dependencies; used by every module of the block but uartle_cmd_fifo
`default_nettype none

package uartle_pkg;

	localparam int unsigned BYTE_W = 8;

	localparam logic [BYTE_W-1:0] CHAR_CR  = 8'd13;
	localparam logic [BYTE_W-1:0] CHAR_LF  = 8'd10;
	localparam logic [BYTE_W-1:0] CHAR_NUL = 8'd0;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_ECHO,
		BK_TRAIL_CR,
		BK_TRAIL_LF
	} back_state_t;

endpackage

`default_nettype wire

@@ hw/rtl/uart_line_echo_unit.sv @@
// uart line echo unit: collects received bytes into a line and echoes the
// line on carriage return. The in channel takes one byte (rx_byte) per
// transaction; the out channel gives out_byte with last set on the final LF.
// Bytes other than CR are stored and give nothing. When LINE_DEPTH-1 bytes
// are held, the next byte (CR included) is dropped and the line starts over.
// A CR echoes the stored bytes up to the first zero byte, at most
// LINE_DEPTH-3 of them, then CR and LF. A CR goes through the command
// queue and the back-end state; each stored byte is then read into the
// line store read register and loaded into the output register, and the run
// gives one result a cycle while out_stall is low, set by the single read
// port of the line store. in_stall stays high while an echo run is being
// played out, so a new line never disturbs it.
// Reset clears the fill count, the queue and the output valid flag; the line
// store is not cleared. When out_stall is high the output register holds its
// transaction and the echo pauses without losing a byte.
// Depends on uartle_pkg, uartle_front, uartle_cmd_fifo, uartle_back.
`default_nettype none

module uart_line_echo_unit #(
	parameter int unsigned LINE_DEPTH = 64
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [uartle_pkg::BYTE_W-1:0] rx_byte,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [uartle_pkg::BYTE_W-1:0]      out_byte,
	output logic                               last
);

	localparam int unsigned AW = $clog2(LINE_DEPTH);

	logic                          busy;
	logic                          cmd_full;
	logic                          cmd_push;
	logic [AW-1:0]                 cmd_len_in;
	logic                          cmd_pop;
	logic [AW-1:0]                 cmd_len_out;
	logic                          cmd_valid;
	logic                          wr_en;
	logic [AW-1:0]                 wr_addr;
	logic [uartle_pkg::BYTE_W-1:0] wr_data;

	uartle_front #(
		.AW(AW),
		.LINE_DEPTH(LINE_DEPTH)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.busy(busy || cmd_valid),
		.cmd_full(cmd_full),
		.cmd_push(cmd_push),
		.cmd_len(cmd_len_in),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);

	uartle_cmd_fifo #(
		.W(AW)
	) u_cmd_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(cmd_push),
		.push_data(cmd_len_in),
		.pop(cmd_pop),
		.pop_data(cmd_len_out),
		.not_empty(cmd_valid),
		.full(cmd_full)
	);

	uartle_back #(
		.AW(AW),
		.LINE_DEPTH(LINE_DEPTH)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.cmd_valid(cmd_valid),
		.cmd_len(cmd_len_out),
		.cmd_pop(cmd_pop),
		.busy(busy),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte(out_byte),
		.last(last)
	);

	// line store is never written while an echo run reads it
	a_no_write_during_echo: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (!busy && !cmd_valid))
		else $error("line store written during echo");

	// the queue never takes a command while full
	a_no_cmd_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push |-> !cmd_full)
		else $error("command queue overflow");

	// last only ever marks the LF trailer
	a_last_is_lf: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last) |-> (out_byte == uartle_pkg::CHAR_LF))
		else $error("last set on a byte other than LF");

	// taking a command always starts the back end
	a_pop_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |=> busy)
		else $error("back end did not start after taking a command");

endmodule

`default_nettype wire

@@ hw/rtl/uartle_front.sv @@
// front end: accepts received bytes, keeps the fill count, issues line store
// writes and echo commands; depends on uartle_pkg
`default_nettype none

module uartle_front #(
	parameter int unsigned AW = 6,
	parameter int unsigned LINE_DEPTH = 64
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [uartle_pkg::BYTE_W-1:0] rx_byte,
	input  wire logic                         busy,
	input  wire logic                         cmd_full,
	output logic                              cmd_push,
	output logic [AW-1:0]                     cmd_len,
	output logic                              wr_en,
	output logic [AW-1:0]                     wr_addr,
	output logic [uartle_pkg::BYTE_W-1:0]     wr_data
);

	localparam logic [AW-1:0] FILL_MAX = AW'(LINE_DEPTH - 1);

	logic [AW-1:0] fill_q;
	logic          accept;
	logic          full_line;
	logic          is_cr;

	// hold off new bytes while an echo still reads the line store or the command queue is full
	assign in_stall  = busy || cmd_full;
	assign accept    = in_valid && !in_stall;
	assign full_line = (fill_q == FILL_MAX);
	assign is_cr     = (rx_byte == uartle_pkg::CHAR_CR);

	assign wr_en    = accept && !full_line && !is_cr;
	assign wr_addr  = fill_q;
	assign wr_data  = rx_byte;
	assign cmd_push = accept && !full_line && is_cr;
	assign cmd_len  = fill_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (accept) begin
			if (full_line || is_cr) begin
				fill_q <= '0;
			end else begin
				fill_q <= fill_q + AW'(1);
			end
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/uartle_cmd_fifo.sv @@
// two-entry command queue between front and back end
// no dependencies
`default_nettype none

module uartle_cmd_fifo #(
	parameter int unsigned W = 6
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] push_data,
	input  wire logic         pop,
	output logic [W-1:0]      pop_data,
	output logic              not_empty,
	output logic              full
);

	logic [W-1:0] entry_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   count_q;
	logic         do_push;
	logic         do_pop;

	assign not_empty = (count_q != 2'd0);
	assign full      = (count_q == 2'd2);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign pop_data  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/uartle_back.sv @@
// back end: holds the line store and plays out one echo run per command,
// stored bytes then CR and LF; depends on uartle_pkg
`default_nettype none

module uartle_back #(
	parameter int unsigned AW = 6,
	parameter int unsigned LINE_DEPTH = 64
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          wr_en,
	input  wire logic [AW-1:0]                 wr_addr,
	input  wire logic [uartle_pkg::BYTE_W-1:0] wr_data,
	input  wire logic                          cmd_valid,
	input  wire logic [AW-1:0]                 cmd_len,
	output logic                               cmd_pop,
	output logic                               busy,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [uartle_pkg::BYTE_W-1:0]      out_byte,
	output logic                               last
);

	localparam logic [AW-1:0] ECHO_MAX = AW'(LINE_DEPTH - 3);

	logic [uartle_pkg::BYTE_W-1:0] store_q [LINE_DEPTH];
	logic [uartle_pkg::BYTE_W-1:0] rdata_q;

	uartle_pkg::back_state_t state_q, state_d;

	logic [AW-1:0]                 len_q, len_d;
	logic [AW-1:0]                 rd_idx_q, rd_idx_d;
	logic                          pend_q, pend_d;
	logic                          ovalid_q;
	logic [uartle_pkg::BYTE_W-1:0] obyte_q;
	logic                          olast_q;

	logic                          out_free;
	logic                          take;
	logic                          rd_en;
	logic                          load;
	logic [uartle_pkg::BYTE_W-1:0] load_byte;
	logic                          load_last;

	assign out_free  = !ovalid_q || !out_stall;
	assign busy      = (state_q != uartle_pkg::BK_IDLE);
	assign out_valid = ovalid_q;
	assign out_byte  = obyte_q;
	assign last      = olast_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= store_q[rd_idx_q];
		end
	end

	always_comb begin
		state_d   = state_q;
		len_d     = len_q;
		rd_idx_d  = rd_idx_q;
		pend_d    = pend_q;
		cmd_pop   = 1'b0;
		take      = 1'b0;
		rd_en     = 1'b0;
		load      = 1'b0;
		load_byte = rdata_q;
		load_last = 1'b0;
		unique case (state_q)
			uartle_pkg::BK_IDLE: begin
				if (cmd_valid) begin
					cmd_pop  = 1'b1;
					len_d    = (cmd_len > ECHO_MAX) ? ECHO_MAX : cmd_len;
					rd_idx_d = '0;
					pend_d   = 1'b0;
					state_d  = uartle_pkg::BK_ECHO;
				end
			end
			uartle_pkg::BK_ECHO: begin
				// one read in flight; a zero byte ends the run early
				take  = pend_q && out_free;
				rd_en = (rd_idx_q != len_q) &&
					(!pend_q || (take && rdata_q != uartle_pkg::CHAR_NUL));
				if (take && rdata_q != uartle_pkg::CHAR_NUL) begin
					load = 1'b1;
				end
				if (rd_en) begin
					rd_idx_d = rd_idx_q + AW'(1);
					pend_d   = 1'b1;
				end else if (take) begin
					pend_d = 1'b0;
				end
				if ((take && rdata_q == uartle_pkg::CHAR_NUL) ||
					(!pend_q && rd_idx_q == len_q)) begin
					state_d = uartle_pkg::BK_TRAIL_CR;
					pend_d  = 1'b0;
				end
			end
			uartle_pkg::BK_TRAIL_CR: begin
				if (out_free) begin
					load      = 1'b1;
					load_byte = uartle_pkg::CHAR_CR;
					state_d   = uartle_pkg::BK_TRAIL_LF;
				end
			end
			uartle_pkg::BK_TRAIL_LF: begin
				if (out_free) begin
					load      = 1'b1;
					load_byte = uartle_pkg::CHAR_LF;
					load_last = 1'b1;
					state_d   = uartle_pkg::BK_IDLE;
				end
			end
			default: begin
				state_d = uartle_pkg::BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= uartle_pkg::BK_IDLE;
			pend_q   <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_q  <= pend_d;
			if (load) begin
				ovalid_q <= 1'b1;
			end else if (!out_stall) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		len_q    <= len_d;
		rd_idx_q <= rd_idx_d;
		if (load) begin
			obyte_q <= load_byte;
			olast_q <= load_last;
		end
	end

endmodule

`default_nettype wire
